[rtl/core/assert_macros.svh]
// assertion macros used by the sha-256 checker file
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/sha256_pkg.sv]
// shared types and constants of the sha-256 block hasher
// no dependencies
`default_nettype none

package sha256_pkg;

	localparam int WORD_W       = 32;
	localparam int BLOCK_WORDS  = 16;
	localparam int ROUNDS       = 64;
	localparam int DIGEST_WORDS = 8;

	localparam int WCNT_W  = $clog2(BLOCK_WORDS);
	localparam int ROUND_W = $clog2(ROUNDS);
	localparam int OCNT_W  = $clog2(DIGEST_WORDS + 1);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IV_TABLE [DIGEST_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// controller to datapath
	typedef struct packed {
		logic               load_word;
		logic               start_block;
		logic               round_en;
		logic [ROUND_W-1:0] round_idx;
		logic               commit;
		logic               emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/sha256_in_if.sv]
// input channel of the sha-256 block hasher: one message word per item
// depends on sha256_pkg
`default_nettype none

interface sha256_in_if;
	logic                  valid;
	logic                  ready;
	sha256_pkg::word_t     message_word;
	logic                  final_word;

	modport source (output valid, output message_word, output final_word, input ready);
	modport sink (input valid, input message_word, input final_word, output ready);
endinterface

`default_nettype wire

[rtl/core/sha256_out_if.sv]
// output channel of the sha-256 block hasher: one digest word per item
// depends on sha256_pkg
`default_nettype none

interface sha256_out_if;
	logic                  valid;
	logic                  ready;
	sha256_pkg::word_t     digest_word;
	logic                  digest_last;

	modport source (output valid, output digest_word, output digest_last, input ready);
	modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

`default_nettype wire

[rtl/core/sha256_ctrl.sv]
// controller of the sha-256 block hasher: word count, round count, block sequencing
// depends on sha256_pkg
`default_nettype none

module sha256_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_final,
	output logic                  in_ready,
	output sha256_pkg::cmd_t      cmd,
	input  wire sha256_pkg::sts_t sts
);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_ROUND  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0]                       state_q;
	logic [sha256_pkg::WCNT_W-1:0]    word_cnt_q;
	logic [sha256_pkg::ROUND_W-1:0]   round_q;
	logic                             final_q;
	logic                             accept;
	logic                             block_full;

	assign in_ready   = (state_q == ST_LOAD);
	assign accept     = in_valid && in_ready;
	assign block_full = (word_cnt_q == sha256_pkg::WCNT_W'(sha256_pkg::BLOCK_WORDS - 1));

	always_comb begin
		cmd.load_word   = accept;
		cmd.start_block = accept && block_full;
		cmd.round_en    = (state_q == ST_ROUND);
		cmd.round_idx   = round_q;
		// a final block waits until the previous digest has drained
		cmd.commit      = (state_q == ST_UPDATE) && !(final_q && sts.out_busy);
		cmd.emit        = final_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= '0;
			round_q    <= '0;
			final_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						word_cnt_q <= word_cnt_q + 1'b1;
						if (block_full) begin
							final_q <= in_final;
							round_q <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == sha256_pkg::ROUND_W'(sha256_pkg::ROUNDS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (cmd.commit) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/sha256_dp.sv]
// datapath of the sha-256 block hasher: schedule window, round unit,
// chaining value and digest output buffer; depends on sha256_pkg
`default_nettype none

module sha256_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha256_pkg::cmd_t  cmd,
	output sha256_pkg::sts_t       sts,
	input  wire sha256_pkg::word_t message_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sha256_pkg::word_t      digest_word,
	output logic                   digest_last
);

	function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (sha256_pkg::WORD_W - n));
	endfunction

	sha256_pkg::word_t win_q [sha256_pkg::BLOCK_WORDS];
	sha256_pkg::word_t var_q [sha256_pkg::DIGEST_WORDS];
	sha256_pkg::word_t cv_q  [sha256_pkg::DIGEST_WORDS];
	sha256_pkg::word_t dig_q [sha256_pkg::DIGEST_WORDS];
	logic [sha256_pkg::OCNT_W-1:0] out_cnt_q;

	sha256_pkg::word_t sig0, sig1, w_next;
	sha256_pkg::word_t big0, big1, ch, maj, t1, t2;
	logic              out_take;

	// schedule: win_q[0] is w[t], the next word enters at the top
	always_comb begin
		sig0   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
		sig1   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
		w_next = sig1 + win_q[9] + sig0 + win_q[0];
	end

	always_comb begin
		big1 = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
		ch   = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		big0 = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
		maj  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1   = var_q[7] + big1 + ch + sha256_pkg::K_TABLE[cmd.round_idx] + win_q[0];
		t2   = big0 + maj;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.round_en) begin
			for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha256_pkg::BLOCK_WORDS-1] <= cmd.load_word ? message_word : w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_block) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				var_q[i] <= cv_q[i];
			end
		end else if (cmd.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				cv_q[i] <= sha256_pkg::IV_TABLE[i];
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				cv_q[i] <= cmd.emit ? sha256_pkg::IV_TABLE[i] : cv_q[i] + var_q[i];
			end
		end
	end

	assign out_take = out_valid && out_ready;

	// digest buffer drains word 0 first while the next message loads
	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.emit) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				dig_q[i] <= cv_q[i] + var_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (cmd.commit && cmd.emit) begin
			out_cnt_q <= sha256_pkg::OCNT_W'(sha256_pkg::DIGEST_WORDS);
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	assign out_valid    = (out_cnt_q != '0);
	assign digest_word  = dig_q[0];
	assign digest_last  = (out_cnt_q == sha256_pkg::OCNT_W'(1));
	assign sts.out_busy = out_valid;

endmodule

`default_nettype wire

[rtl/core/sha256_block_hasher.sv]
// sha-256 block hasher top level: joins controller and datapath to the channels
// depends on sha256_pkg, sha256_in_if, sha256_out_if, sha256_ctrl, sha256_dp
//
// usage:
// - message channel: padded message as 32-bit big-endian words; every 16 words
//   form one block, final_word on the sixteenth word of a block ends the message
//   (a final flag on any other word is ignored)
// - digest channel: eight digest words, word 0 first, digest_last on the eighth
// - a block loads its 16 words one word per cycle while words are offered, then
//   runs 64 rounds of one round per cycle, then the chaining update; the round
//   unit is the limit on sustained input
// - the first digest word is valid once the rounds and the chaining update of
//   the final block are done; the rest follow one per cycle when taken
// - the message channel is not ready during the rounds and the update state
// - the digest sits in its own buffer, so a stalled receiver does not hold up
//   the next message; only a further final block waits in its update state
//   until the previous digest has been taken
// - reset clears the word count, empties the digest buffer and loads the
//   initial hash values; no clearing pass is needed
`default_nettype none

module sha256_block_hasher (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha256_in_if.sink     message,
	sha256_out_if.source  digest
);

	sha256_pkg::cmd_t cmd;
	sha256_pkg::sts_t sts;

	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (message.valid),
		.in_final (message.final_word),
		.in_ready (message.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sha256_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.message_word (message.message_word),
		.out_valid    (digest.valid),
		.out_ready    (digest.ready),
		.digest_word  (digest.digest_word),
		.digest_last  (digest.digest_last)
	);

endmodule

`default_nettype wire

[rtl/core/sha256_checker.sv]
// port-level checks of the sha-256 block hasher, bound to the top level
// depends on assert_macros.svh and sha256_pkg
`default_nettype none

`include "assert_macros.svh"

module sha256_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire sha256_pkg::word_t digest_word,
	input wire logic              digest_last
);

	// a stalled digest word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(digest_last))
	// digest words come back to back until the last one
	`ASSERT_NEXT(a_out_burst, clk, arst_n, out_valid && out_ready && !digest_last, out_valid)
	// the buffer empties after the last word
	`ASSERT_NEXT(a_out_end, clk, arst_n, out_valid && out_ready && digest_last, !out_valid)
	// a digest only appears straight after an update cycle
	`ASSERT_SAME(a_out_start, clk, arst_n, $rose(out_valid), !$past(in_ready))
	// the message side only stops being ready after it has taken a word
	`ASSERT_SAME(a_in_idle, clk, arst_n, in_valid && !in_ready && $past(in_ready) && !$past(in_valid), 1'b0)

endmodule

bind sha256_block_hasher sha256_checker u_sha256_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (message.valid),
	.in_ready    (message.ready),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.digest_last (digest.digest_last)
);

`default_nettype wire
